@@ rtl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Character codes, lexical mode codes, bracket kinds and the result word type
// shared by the checker modules.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Characters that take part in bracket and lexical tracking.
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Lexical modes.
    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_SLASH      = 3'd1;
    localparam logic [2:0] MODE_BLOCK      = 3'd2;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd3;
    localparam logic [2:0] MODE_LINE       = 3'd4;
    localparam logic [2:0] MODE_DQ         = 3'd5;
    localparam logic [2:0] MODE_SQ         = 3'd6;

    // Bracket kinds, as stored on the stack and reported as mismatch.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PAREN   = 2'd1;
    localparam logic [1:0] KIND_BRACKET = 2'd2;
    localparam logic [1:0] KIND_BRACE   = 2'd3;

    // Width of one stack entry.
    localparam int KIND_W = 2;

    // One result word.
    typedef struct packed {
        logic       overflow;
        logic       unclosed_at_end;
        logic [1:0] mismatch;
    } res_t;

    function automatic logic [1:0] opener_kind(input logic [7:0] c);
        logic [1:0] k;
        k = KIND_NONE;
        if (c == CH_LPAREN) k = KIND_PAREN;
        else if (c == CH_LBRACK) k = KIND_BRACKET;
        else if (c == CH_LBRACE) k = KIND_BRACE;
        return k;
    endfunction

    function automatic logic [1:0] closer_kind(input logic [7:0] c);
        logic [1:0] k;
        k = KIND_NONE;
        if (c == CH_RPAREN) k = KIND_PAREN;
        else if (c == CH_RBRACK) k = KIND_BRACKET;
        else if (c == CH_RBRACE) k = KIND_BRACE;
        return k;
    endfunction

endpackage

@@ rtl/bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker
// Checks bracket balance of C source text streamed one byte per word.
// ----------------------------------------------------------------------------
// Each input word carries one source byte, with tlast on the final byte of a
// text. Every input word yields exactly one result word, in order, in the
// cycle after it is taken when the output is free. The block takes one byte
// every cycle while s_tready is high: the top of the opener stack lives in a
// register and the entry below it is read ahead from the single-write,
// single-read stack RAM, so a pop never waits on RAM latency. The result
// passes through an output register and a skid stage; s_tready falls only
// when both hold words. Brackets inside comments and quoted literals are
// ignored; escapes are not recognised. No clearing pass is needed after
// reset. An opener that meets a full stack is dropped and flagged as overflow.
// ----------------------------------------------------------------------------
module bracket_balance_checker import bbc_pkg::*; #(
    parameter int STACK_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] ch
    input  logic       s_tlast,  // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata   // [1:0] mismatch, [2] unclosed_at_end,
                                 // [3] overflow, [7:4] zero
);

    logic in_accept;
    res_t core_res;
    res_t out_res;

    assign in_accept = s_tvalid && s_tready;

    // Mode machine and stack.
    bbc_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_ch     (s_tdata),
        .in_last   (s_tlast),
        .res       (core_res)
    );

    // Result buffering.
    bbc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {4'b0000, out_res};

endmodule

@@ rtl/bbc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bbc_core.sv @@
// ----------------------------------------------------------------------------
// Bracket checker core
// Lexical mode machine and opener stack. The top entry sits in a register and
// the entry below it is prefetched from the stack RAM, so pops may follow one
// another in consecutive cycles.
// ----------------------------------------------------------------------------
module bbc_core import bbc_pkg::*; #(
    parameter int STACK_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_ch,
    input  logic       in_last,
    output res_t       res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [2:0]        mode_reg, mode_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [KIND_W-1:0] tos_reg, tos_next;
    logic [KIND_W-1:0] below;

    logic              code_en;
    logic [1:0]        ok, ck, top;
    logic [CW-1:0]     count_step;
    logic [CW-1:0]     rd_addr_full;
    logic [AW-1:0]     rd_addr;
    logic              push_wr;

    // Lexical mode machine: decides whether this word is seen as code.
    always_comb begin
        mode_next = mode_reg;
        code_en   = 1'b0;
        unique case (mode_reg)
            MODE_SLASH: begin
                if (in_ch == CH_STAR) mode_next = MODE_BLOCK;
                else if (in_ch == CH_SLASH) mode_next = MODE_LINE;
                else begin
                    mode_next = MODE_NORMAL;
                    code_en   = 1'b1;
                end
            end
            MODE_BLOCK: begin
                if (in_ch == CH_STAR) mode_next = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                if (in_ch == CH_SLASH) mode_next = MODE_NORMAL;
                else if (in_ch != CH_STAR) mode_next = MODE_BLOCK;
            end
            MODE_LINE: begin
                if (in_ch == CH_NEWLINE) mode_next = MODE_NORMAL;
            end
            MODE_DQ: begin
                if (in_ch == CH_DQUOTE) mode_next = MODE_NORMAL;
            end
            MODE_SQ: begin
                if (in_ch == CH_SQUOTE) mode_next = MODE_NORMAL;
            end
            default: begin
                mode_next = MODE_NORMAL;
                code_en   = 1'b1;
            end
        endcase

        // Quotes and slashes in code open a new lexical mode.
        if (code_en) begin
            if (in_ch == CH_SQUOTE) mode_next = MODE_SQ;
            else if (in_ch == CH_DQUOTE) mode_next = MODE_DQ;
            else if (in_ch == CH_SLASH) mode_next = MODE_SLASH;
        end
        if (in_last) mode_next = MODE_NORMAL;
    end

    // Stack update: push, pop with compare, end-of-text handling.
    always_comb begin
        ok          = code_en ? opener_kind(in_ch) : KIND_NONE;
        ck          = code_en ? closer_kind(in_ch) : KIND_NONE;
        count_step  = count_reg;
        tos_next    = tos_reg;
        push_wr     = 1'b0;
        top         = KIND_NONE;
        res         = '0;

        if (ok != KIND_NONE) begin
            if (count_reg != CW'(STACK_DEPTH)) begin
                push_wr    = 1'b1;
                count_step = count_reg + 1'b1;
                tos_next   = ok;
            end else begin
                res.overflow = 1'b1;
            end
        end else if (ck != KIND_NONE) begin
            if (count_reg != '0) begin
                top        = tos_reg;
                count_step = count_reg - 1'b1;
                tos_next   = below;
            end
            if (top != ck) res.mismatch = ck;
        end

        res.unclosed_at_end = in_last && (count_step != '0);
        count_next          = in_last ? '0 : count_step;

        // Prefetch the entry under the new top; unused while fewer than two.
        rd_addr_full = count_next - CW'(2);
        rd_addr      = (count_next >= CW'(2)) ? rd_addr_full[AW-1:0] : '0;
    end

    // Stack entries; a push writes at the old count and the read goes to the entry
    // under it, so the ports share an address only on a push to an empty stack.
    bbc_ram #(
        .WIDTH (KIND_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (in_accept && push_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (ok),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (below)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= '0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    // Top-of-stack register.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            tos_reg <= tos_next;
        end
    end

endmodule

@@ rtl/bbc_skid.sv @@
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with a skid stage, so that a word is taken in while a
// finished result still waits at the output.
// ----------------------------------------------------------------------------
module bbc_skid import bbc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic in_take;

    assign in_ready = !skid_valid_reg;
    assign in_take  = in_valid && in_ready;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (out_valid_reg && out_ready) begin
                if (skid_valid_reg) skid_valid_reg <= 1'b0;
                else out_valid_reg <= in_take;
            end else if (!out_valid_reg) begin
                out_valid_reg <= in_take;
            end else begin
                if (in_take) skid_valid_reg <= 1'b1;
            end
        end
    end

    // Data path.
    always_ff @(posedge aclk) begin
        priority if (out_valid_reg && out_ready) begin
            if (skid_valid_reg) out_data_reg <= skid_data_reg;
            else if (in_take) out_data_reg <= in_data;
        end else if (!out_valid_reg) begin
            if (in_take) out_data_reg <= in_data;
        end else begin
            if (in_take) skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/bbc_checker.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker port assertions
// Checks the top level's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module bbc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The input only stalls when the output stage holds a word.
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // After a taken input word, the output holds a valid word in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("taken word produced no result");

    // A dropped opener never reports a mismatch in the same word, and bits [7:4] are zero.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && (m_tdata[1:0] != 2'd0)) && (m_tdata[7:4] == 4'd0))
        else $error("inconsistent result flags");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
